/* rtl/core/sbq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg - shared definitions for the stereo biquad equaliser
// default sizes, register map constants, sequencer codes and control bundle
// ----------------------------------------------------------------------------
package sbq_pkg;

  // default sizes
  localparam int BANDS_DEF        = 4;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 20;

  // q4.16 coefficients
  localparam int COEF_FRAC = 16;

  // register file: one feedforward and one feedback word for each of four bands
  localparam int REG_BANDS   = 4;
  localparam int BAND_IDX_W  = 2;
  localparam int APB_ADDR_W  = 6;
  localparam int APB_DATA_W  = 64;
  localparam int REG_SEL_LSB = 3;
  localparam logic [63:0] FF_RESET = 64'd65536;

  // multiply-accumulate step counter
  localparam int TAP_W = 3;
  localparam logic [TAP_W-1:0] TAP_B0   = 3'd0;
  localparam logic [TAP_W-1:0] TAP_B1   = 3'd1;
  localparam logic [TAP_W-1:0] TAP_B2   = 3'd2;
  localparam logic [TAP_W-1:0] TAP_A1   = 3'd3;
  localparam logic [TAP_W-1:0] TAP_A2   = 3'd4;
  localparam logic [TAP_W-1:0] TAP_LAST = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/sbq_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_in_if - stereo sample input channel
// valid/ready handshake carrying one left/right sample pair
// ----------------------------------------------------------------------------
interface sbq_in_if #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface
`default_nettype wire

/* rtl/core/sbq_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_out_if - stereo sample output channel
// valid/ready handshake carrying one filtered left/right pair
// ----------------------------------------------------------------------------
interface sbq_out_if #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/stereo_biquad_cascade_eq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq - stereo cascaded biquad equaliser
// two channels, each through BANDS direct-form-I sections on one shared mac
// ----------------------------------------------------------------------------
// A stereo pair is taken on the samples channel when the block is idle; the
// left sample runs through bands 0 to BANDS-1, then the right sample does the
// same with its own delay line, and the filtered pair is offered on the
// filtered channel from an output register, so a waiting result never blocks
// the next input. Each section computes b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
// with signed q4.16 coefficients, rounds half up to an integer and saturates
// to SAMPLE_WIDTH bits before feeding the next band. All products go through a
// single multiplier: a section forms its five products one after the other,
// then drains the product register into the accumulator, then rounds and
// writes the delay row back. A new pair is not taken until the filtered pair
// has been moved into the output register and the block is idle again.
// Coefficients sit on an apb-style port, one 64-bit word per register at byte
// address 8*index (feedforward of band b at index 2b, feedback at 2b+1); they
// are meant to be written only while the block is idle. Delay state resets to
// zero.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade_eq #(
  parameter int BANDS        = sbq_pkg::BANDS_DEF,
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  sbq_in_if.sink                              samples,
  sbq_out_if.source                           filtered,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sbq_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sbq_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sbq_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import sbq_pkg::*;

  localparam int ROWS  = 2 * BANDS;            // one delay row per channel and band
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] LEFT_LAST = ROW_W'(BANDS - 1);
  localparam logic [ROW_W-1:0] RIGHT_0   = ROW_W'(BANDS);

  // positions within a delay row
  localparam int D_X1 = 0;
  localparam int D_X2 = 1;
  localparam int D_Y1 = 2;
  localparam int D_Y2 = 3;
  localparam int TAPS = 4;

  // coefficient registers
  logic [3*COEF_WIDTH-1:0] ff [REG_BANDS];
  logic [2*COEF_WIDTH-1:0] fb [REG_BANDS];

  // sequencer
  seq_state_t        state;
  seq_state_t        state_next;
  logic [TAP_W-1:0]  tap;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  band_row;
  logic [BAND_IDX_W-1:0] band;
  mac_ctrl_t         mac_ctrl;
  logic              accept;
  logic              out_load;
  logic              out_valid;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] dly [ROWS][TAPS];
  logic signed [SAMPLE_WIDTH-1:0] x;          // input of the current band
  logic signed [SAMPLE_WIDTH-1:0] rin;        // right sample waiting its turn
  logic signed [SAMPLE_WIDTH-1:0] lres;       // left result waiting for the right
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;
  logic signed [SAMPLE_WIDTH-1:0] operand;
  logic signed [COEF_WIDTH-1:0]   coef;
  logic signed [SAMPLE_WIDTH-1:0] y;

  sbq_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ff      (ff),
    .fb      (fb)
  );

  sbq_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (coef),
    .sample (operand),
    .y      (y)
  );

  // handshakes, nothing is taken while reset is held
  assign samples.ready      = (state == ST_IDLE) && !rst;
  assign accept             = samples.valid && samples.ready;
  assign filtered.valid     = out_valid;
  assign filtered.left_out  = out_left;
  assign filtered.right_out = out_right;

  // rows 0..BANDS-1 are the left channel, the rest the right
  assign band_row = (row >= RIGHT_0) ? row - RIGHT_0 : row;
  assign band     = BAND_IDX_W'(band_row);

  // operand and coefficient for the current mac step
  always_comb begin
    unique case (tap)
      TAP_B0: begin
        operand = x;
        coef    = ff[band][0*COEF_WIDTH +: COEF_WIDTH];
      end
      TAP_B1: begin
        operand = dly[row][D_X1];
        coef    = ff[band][1*COEF_WIDTH +: COEF_WIDTH];
      end
      TAP_B2: begin
        operand = dly[row][D_X2];
        coef    = ff[band][2*COEF_WIDTH +: COEF_WIDTH];
      end
      TAP_A1: begin
        operand = dly[row][D_Y1];
        coef    = fb[band][0*COEF_WIDTH +: COEF_WIDTH];
      end
      TAP_A2: begin
        operand = dly[row][D_Y2];
        coef    = fb[band][1*COEF_WIDTH +: COEF_WIDTH];
      end
      default: begin
        // drain step, multiplier idle
        operand = x;
        coef    = '0;
      end
    endcase
  end

  // next state and mac control
  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctrl.clear  = (tap == TAP_B0);
        mac_ctrl.mul_en = (tap != TAP_LAST);
        mac_ctrl.acc_en = (tap != TAP_B0);
        mac_ctrl.sub    = (tap >= TAP_A1);   // feedback terms are subtracted
        if (tap == TAP_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = (row == ROW_LAST) ? ST_DONE : ST_MAC;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid || filtered.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // control state and delay rows
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap       <= TAP_B0;
      row       <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        for (int k = 0; k < TAPS; k++) begin
          dly[r][k] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (accept) begin
        tap <= TAP_B0;
        row <= '0;
      end
      if (state == ST_MAC) begin
        tap <= (tap == TAP_LAST) ? TAP_B0 : tap + TAP_W'(1);
      end
      if (state == ST_ROUND) begin
        // shift the section's delay line by one sample
        dly[row][D_X1] <= x;
        dly[row][D_X2] <= dly[row][D_X1];
        dly[row][D_Y1] <= y;
        dly[row][D_Y2] <= dly[row][D_Y1];
        row <= (row == ROW_LAST) ? '0 : row + ROW_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= samples.left_sample;
      rin <= samples.right_sample;
    end
    if (state == ST_ROUND) begin
      if (row == LEFT_LAST) begin
        // left chain finished, start the right one
        lres <= y;
        x    <= rin;
      end else begin
        x <= y;
      end
    end
    if (out_load) begin
      out_left  <= lres;
      out_right <= x;
    end
  end

  // an accepted transaction always starts at the first step of the first row
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MAC) && (tap == TAP_B0) && (row == '0))
    else $error("sequencer did not start at first band");

  // rounding only follows the drain step
  a_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> ($past(state) == ST_MAC) && ($past(tap) == TAP_LAST))
    else $error("round without complete accumulation");

  // the step counter rests at zero outside the mac phase
  a_tap_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MAC) |-> (tap == TAP_B0))
    else $error("step counter not reset");

  // leaving the done state always presents a result
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_load |=> out_valid && (state == ST_IDLE) && (row == '0))
    else $error("result not loaded on completion");

endmodule
`default_nettype wire

/* rtl/core/sbq_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_regs - coefficient register file
// apb-style write/read of the per-band feedforward and feedback words
// ----------------------------------------------------------------------------
module sbq_regs #(
  parameter int COEF_WIDTH = sbq_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sbq_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [sbq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [sbq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [3*COEF_WIDTH-1:0]         ff [sbq_pkg::REG_BANDS],
  output logic      [2*COEF_WIDTH-1:0]         fb [sbq_pkg::REG_BANDS]
);
  import sbq_pkg::*;

  localparam int FF_W = 3 * COEF_WIDTH;
  localparam int FB_W = 2 * COEF_WIDTH;

  logic                  wr_en;
  logic                  sel_fb;
  logic [BAND_IDX_W-1:0] sel_band;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign sel_fb   = paddr[REG_SEL_LSB];
  assign sel_band = paddr[REG_SEL_LSB+1 +: BAND_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_BANDS; i++) begin
        ff[i] <= FF_W'(FF_RESET);
        fb[i] <= '0;
      end
    end else if (wr_en) begin
      if (sel_fb) begin
        fb[sel_band] <= pwdata[FB_W-1:0];
      end else begin
        ff[sel_band] <= pwdata[FF_W-1:0];
      end
    end
  end

  // read back, zero extended
  always_comb begin
    if (sel_fb) begin
      prdata = APB_DATA_W'(fb[sel_band]);
    end else begin
      prdata = APB_DATA_W'(ff[sel_band]);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sbq_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_mac - shared multiply-accumulate unit
// registered product, accumulator, round half up and saturate to a sample
// ----------------------------------------------------------------------------
module sbq_mac #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sbq_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire sbq_pkg::mac_ctrl_t             ctrl,
  input  wire logic signed [COEF_WIDTH-1:0]   coef,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed      [SAMPLE_WIDTH-1:0] y
);
  import sbq_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int AW = PW + 3;   // five terms

  localparam logic signed [AW-1:0] HALF =
    {{(AW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic                 prod_sub;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] q;

  assign prod_ext = {{(AW-PW){prod[PW-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod     <= coef * sample;
      prod_sub <= ctrl.sub;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
    end
  end

  // floor after adding one half
  assign rnd = acc + HALF;
  assign q   = rnd >>> COEF_FRAC;

  always_comb begin
    if (q > SAT_HI) begin
      y = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (q < SAT_LO) begin
      y = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y = q[SAMPLE_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire
